### sv/dtc_pkg.sv
// ----------------------------------------------------------------------------
// Divider and timer counter package
// Shared types, codes and constants for the DIV/TIMA/TMA/TAC timer block.
// ----------------------------------------------------------------------------
package dtc_pkg;

	localparam int unsigned DATA_W             = 8;
	localparam int unsigned CYC_W              = 8;
	localparam int unsigned CYC_N              = 2 ** CYC_W;
	localparam int unsigned TAC_W              = 3;
	localparam int unsigned PERIOD_W           = 12;
	localparam int unsigned TAC_EN_BIT         = 2;
	localparam int unsigned DIVIDER_PERIOD_DEF = 256;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_TIMA = 2'd1;
	localparam logic [1:0] REG_TMA  = 2'd2;
	localparam logic [1:0] REG_TAC  = 2'd3;

	localparam logic [1:0] RATE_1024 = 2'd0;
	localparam logic [1:0] RATE_16   = 2'd1;
	localparam logic [1:0] RATE_64   = 2'd2;
	localparam logic [1:0] RATE_256  = 2'd3;

	typedef struct packed {
		logic              fire;
		logic [1:0]        cmd;
		logic [1:0]        reg_index;
		logic [DATA_W-1:0] write_data;
		logic [CYC_W-1:0]  cycle_count;
	} dtc_op_t;

	function automatic logic signed [PERIOD_W-1:0] rate_of(input logic [1:0] sel);
		logic signed [PERIOD_W-1:0] rate;
		case (sel)
			RATE_1024: rate = PERIOD_W'(12'h400);
			RATE_16:   rate = PERIOD_W'(12'h010);
			RATE_64:   rate = PERIOD_W'(12'h040);
			RATE_256:  rate = PERIOD_W'(12'h100);
			default:   rate = PERIOD_W'(12'h100);
		endcase
		return rate;
	endfunction

endpackage

### sv/dtc_divider.sv
// ----------------------------------------------------------------------------
// Divider register
// Cycle accumulator and the 8-bit DIV register that counts whole periods.
// ----------------------------------------------------------------------------
module dtc_divider #(
	parameter int unsigned DIVIDER_PERIOD = dtc_pkg::DIVIDER_PERIOD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dtc_pkg::dtc_op_t             op,
	output logic [dtc_pkg::DATA_W-1:0]   div_value
);
	import dtc_pkg::*;

	localparam int unsigned AW = $clog2(DIVIDER_PERIOD);
	localparam int unsigned QW = $clog2(CYC_N / DIVIDER_PERIOD + 2);

	logic [QW-1:0]     quot_tbl [CYC_N];
	logic [AW-1:0]     rem_tbl  [CYC_N];
	logic [AW-1:0]     acc_q;
	logic [AW-1:0]     acc_n;
	logic [AW:0]       sum;
	logic              carry;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W-1:0] div_n;

	for (genvar i = 0; i < CYC_N; i++) begin : g_tbl
		assign quot_tbl[i] = QW'(i / DIVIDER_PERIOD);
		assign rem_tbl[i]  = AW'(i % DIVIDER_PERIOD);
	end

	always_comb begin
		sum   = {1'b0, acc_q} + {1'b0, rem_tbl[op.cycle_count]};
		carry = 1'b0;
		acc_n = acc_q;
		div_n = div_q;
		if (op.fire) begin
			case (op.cmd)
				CMD_TICK: begin
					if (sum >= (AW + 1)'(DIVIDER_PERIOD)) begin
						carry = 1'b1;
						acc_n = AW'(sum - (AW + 1)'(DIVIDER_PERIOD));
					end else begin
						acc_n = AW'(sum);
					end
					div_n = div_q + DATA_W'(quot_tbl[op.cycle_count]) + DATA_W'(carry);
				end
				CMD_WRITE: begin
					if (op.reg_index == REG_DIV) begin
						div_n = '0;
					end
				end
				default: begin
					div_n = div_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			div_q <= '0;
		end else begin
			acc_q <= acc_n;
			div_q <= div_n;
		end
	end

	assign div_value = div_q;

	a_acc_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, acc_q} < (AW + 1)'(DIVIDER_PERIOD))
		else $error("divider accumulator holds a full period");

endmodule

### sv/dtc_timer.sv
// ----------------------------------------------------------------------------
// Timer counter
// TIMA, TMA and TAC registers with the signed period counter.
// ----------------------------------------------------------------------------
module dtc_timer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dtc_pkg::dtc_op_t            op,
	output logic [dtc_pkg::DATA_W-1:0]  timer_count,
	output logic [dtc_pkg::DATA_W-1:0]  timer_modulo,
	output logic [dtc_pkg::TAC_W-1:0]   timer_control,
	output logic                        overflow_irq
);
	import dtc_pkg::*;

	logic [DATA_W-1:0]          tima_q;
	logic [DATA_W-1:0]          tima_n;
	logic [DATA_W-1:0]          tma_q;
	logic [DATA_W-1:0]          tma_n;
	logic [TAC_W-1:0]           tac_q;
	logic [TAC_W-1:0]           tac_n;
	logic signed [PERIOD_W-1:0] period_q;
	logic signed [PERIOD_W-1:0] period_n;
	logic signed [PERIOD_W-1:0] cyc_ext;
	logic signed [PERIOD_W-1:0] pdiff;
	logic                       irq;

	assign cyc_ext = $signed({{(PERIOD_W - CYC_W){1'b0}}, op.cycle_count});
	assign pdiff   = period_q - cyc_ext;

	always_comb begin
		tima_n   = tima_q;
		tma_n    = tma_q;
		tac_n    = tac_q;
		period_n = period_q;
		irq      = 1'b0;
		if (op.fire) begin
			case (op.cmd)
				CMD_TICK: begin
					if (tac_q[TAC_EN_BIT]) begin
						if (pdiff <= 0) begin
							period_n = rate_of(tac_q[1:0]);
							if (tima_q == {DATA_W{1'b1}}) begin
								tima_n = tma_q;
								irq    = 1'b1;
							end else begin
								tima_n = tima_q + 1'b1;
							end
						end else begin
							period_n = pdiff;
						end
					end
				end
				CMD_WRITE: begin
					case (op.reg_index)
						REG_TIMA: tima_n = op.write_data;
						REG_TMA:  tma_n  = op.write_data;
						REG_TAC: begin
							tac_n = op.write_data[TAC_W-1:0];
							if (op.write_data[1:0] != tac_q[1:0]) begin
								period_n = rate_of(op.write_data[1:0]);
							end
						end
						default: tima_n = tima_q;
					endcase
				end
				default: begin
					tima_n = tima_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tima_q   <= '0;
			tma_q    <= '0;
			tac_q    <= '0;
			period_q <= '0;
		end else begin
			tima_q   <= tima_n;
			tma_q    <= tma_n;
			tac_q    <= tac_n;
			period_q <= period_n;
		end
	end

	assign timer_count   = tima_q;
	assign timer_modulo  = tma_q;
	assign timer_control = tac_q;
	assign overflow_irq  = irq;

	a_period_not_negative: assert property (@(posedge clk) disable iff (!arst_n)
		period_q >= 0)
		else $error("period counter went negative");

	a_wrap_loads_modulo: assert property (@(posedge clk) disable iff (!arst_n)
		irq |=> tima_q == $past(tma_q))
		else $error("TIMA did not load TMA on wrap");

	a_rate_change_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		op.fire && op.cmd == CMD_WRITE && op.reg_index == REG_TAC
		&& op.write_data[1:0] != tac_q[1:0]
		|=> period_q == rate_of(tac_q[1:0]))
		else $error("period counter missed reload on rate change");

endmodule

### sv/divider_and_timer_counter_top.sv
// ----------------------------------------------------------------------------
// Divider and timer counter
// Bus-accessed DIV/TIMA/TMA/TAC timer driven by cycle tick items.
//
// Channel  Dir  tdata                                   tuser
// s_*      in   [7:0] write_data, [15:8] cycle_count    [1:0] cmd, [3:2] reg_index
// m_*      out  [7:0] read_data, [8] overflow_irq, pad  none
//
// Every item passes from acceptance into the input register, then through
// the register update into the result register.
// One item is accepted per cycle; the result register frees as soon as it
// is taken, so the input side stalls only while a result waits on m_tready.
// Reset clears all timer registers, the divider and both valid flags.
// ----------------------------------------------------------------------------
module divider_and_timer_counter_top #(
	parameter int unsigned DIVIDER_PERIOD = dtc_pkg::DIVIDER_PERIOD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // write_data, cycle_count
	input  logic [3:0]  s_tuser,   // cmd, reg_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data, overflow_irq, zero pad
);
	import dtc_pkg::*;

	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [1:0]        idx_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic [CYC_W-1:0]  cyc_s1;
	logic              m_valid_q;
	logic [DATA_W-1:0] rd_q;
	logic              irq_q;
	logic              out_free;
	logic              fire;
	logic              in_acc;
	dtc_op_t           op;
	logic [DATA_W-1:0] div_value;
	logic [DATA_W-1:0] tima;
	logic [DATA_W-1:0] tma;
	logic [TAC_W-1:0]  tac;
	logic              irq;
	logic [DATA_W-1:0] reg_mux;
	logic [DATA_W-1:0] rd;

	assign out_free = !m_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= s_tuser[1:0];
			idx_s1   <= s_tuser[3:2];
			wdata_s1 <= s_tdata[7:0];
			cyc_s1   <= s_tdata[15:8];
		end
		if (fire) begin
			rd_q  <= rd;
			irq_q <= irq;
		end
	end

	assign op = '{fire: fire, cmd: cmd_s1, reg_index: idx_s1,
		write_data: wdata_s1, cycle_count: cyc_s1};

	dtc_divider #(
		.DIVIDER_PERIOD(DIVIDER_PERIOD)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.div_value(div_value)
	);

	dtc_timer u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.timer_count  (tima),
		.timer_modulo (tma),
		.timer_control(tac),
		.overflow_irq (irq)
	);

	always_comb begin
		case (idx_s1)
			REG_DIV:  reg_mux = div_value;
			REG_TIMA: reg_mux = tima;
			REG_TMA:  reg_mux = tma;
			REG_TAC:  reg_mux = DATA_W'(tac);
			default:  reg_mux = div_value;
		endcase
		rd = (cmd_s1 == CMD_READ) ? reg_mux : '0;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, irq_q, rd_q};

	a_irq_has_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && irq_q |-> rd_q == '0)
		else $error("result carries both read data and an interrupt");

	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_valid_q)
		else $error("item lost between stages");

	a_empty_output_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_tready)
		else $error("input stalled with an empty result register");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Divider and timer counter testbench
// Drives bus reads, bus writes and cycle ticks into the timer stream port,
// predicts results from its copy of DIV, TIMA, TMA and TAC or the table,
// and compares each output item in order. A short table of directed items
// comes first, then random traffic with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
	import dtc_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 550;
	localparam int LONG_HOLD = 400;
	localparam int END_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DIRECTED_ROWS = 26;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [1:0]        reg_index;
		logic [DATA_W-1:0] write_data;
		logic [CYC_W-1:0]  cycle_count;
		logic              from_table;
		logic [DATA_W-1:0] want_read;
		logic              want_irq;
	} timer_op_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq;
	} timer_result_t;

	typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_TOGGLE} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	logic [DATA_W-1:0]          div_count = '0;
	logic [8:0]                 div_acc = '0;
	logic [DATA_W-1:0]          tima = '0;
	logic [DATA_W-1:0]          tma = '0;
	logic [TAC_W-1:0]           tac = '0;
	logic signed [PERIOD_W-1:0] period_left = '0;

	timer_result_t timer_result_q[$];
	timer_op_t     directed_rows[0:DIRECTED_ROWS-1];
	int            error_count = 0;
	int            idle_cycles = 0;
	int            burst_left = 0;
	bit            hold_off_req = 1'b0;

	divider_and_timer_counter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic signed [PERIOD_W-1:0] period_for(input logic [1:0] sel);
		case (sel)
			RATE_1024: return PERIOD_W'(1024);
			RATE_16:   return PERIOD_W'(16);
			RATE_64:   return PERIOD_W'(64);
			default:   return PERIOD_W'(256);
		endcase
	endfunction

	function automatic timer_result_t predict_timer(input timer_op_t op);
		timer_result_t res;
		logic [1:0] old_rate;
		logic signed [PERIOD_W-1:0] cycles;
		res = '0;
		case (op.cmd)
			CMD_TICK: begin
				div_acc = div_acc + 9'(op.cycle_count);
				while (div_acc >= DIVIDER_PERIOD_DEF) begin
					div_acc = div_acc - 9'(DIVIDER_PERIOD_DEF);
					div_count = div_count + 1'b1;
				end
				if (tac[TAC_EN_BIT]) begin
					cycles = PERIOD_W'(op.cycle_count);
					period_left = period_left - cycles;
					if (period_left <= 0) begin
						period_left = period_for(tac[1:0]);
						if (tima == 8'hFF) begin
							tima = tma;
							res.irq = 1'b1;
						end else begin
							tima = tima + 1'b1;
						end
					end
				end
			end
			CMD_READ: begin
				case (op.reg_index)
					REG_DIV:  res.read_data = div_count;
					REG_TIMA: res.read_data = tima;
					REG_TMA:  res.read_data = tma;
					default:  res.read_data = {{(DATA_W-TAC_W){1'b0}}, tac};
				endcase
			end
			CMD_WRITE: begin
				case (op.reg_index)
					REG_DIV:  div_count = '0;
					REG_TIMA: tima = op.write_data;
					REG_TMA:  tma = op.write_data;
					default: begin
						old_rate = tac[1:0];
						tac = op.write_data[TAC_W-1:0];
						if (old_rate != tac[1:0])
							period_left = period_for(tac[1:0]);
					end
				endcase
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic timer_op_t random_op();
		timer_op_t op;
		int pick;
		op = '0;
		op.write_data = DATA_W'($urandom_range(0, 255));
		op.cycle_count = CYC_W'($urandom_range(0, 255));
		op.reg_index = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			op.cmd = CMD_TICK;
			case ($urandom_range(0, 5))
				0:       op.cycle_count = '0;
				1:       op.cycle_count = '1;
				2, 3:    op.cycle_count = CYC_W'($urandom_range(0, 24));
				default: ;
			endcase
		end else if (pick < 75) begin
			op.cmd = CMD_READ;
		end else if (pick < 95) begin
			op.cmd = CMD_WRITE;
			if (op.reg_index == REG_TIMA && $urandom_range(0, 1) == 1)
				op.write_data = DATA_W'($urandom_range(250, 255));
			if (op.reg_index == REG_TAC && $urandom_range(0, 2) != 0)
				op.write_data[TAC_EN_BIT] = 1'b1;
		end else begin
			op.cmd = CMD_NONE;
		end
		return op;
	endfunction

	task automatic note_error(input string what, input int want, input int got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch: %s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic offer(input timer_op_t op);
		timer_result_t res;
		s_tvalid <= 1'b1;
		s_tuser <= {op.reg_index, op.cmd};
		s_tdata <= {op.cycle_count, op.write_data};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res = predict_timer(op);
		if (op.from_table) begin
			res.read_data = op.want_read;
			res.irq = op.want_irq;
		end
		timer_result_q.push_back(res);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (timer_result_q.size() != 0);
	endtask

	initial begin : drive_items
		directed_rows = '{
			'{CMD_READ,  REG_DIV,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,  REG_TIMA, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,  REG_TMA,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,  REG_TAC,  8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
			'{CMD_NONE,  REG_TAC,  8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
			'{CMD_WRITE, REG_TAC,  8'h04, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_TICK,  REG_DIV,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
			'{CMD_READ,  REG_TIMA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE, REG_TAC,  8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,  REG_TAC,  8'h00, 8'h00, 1'b1, 8'h07, 1'b0},
			'{CMD_WRITE, REG_TMA,  8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,  REG_TMA,  8'h00, 8'h00, 1'b1, 8'hFF, 1'b0},
			'{CMD_WRITE, REG_TIMA, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
			'{CMD_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
			'{CMD_READ,  REG_TIMA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
			'{CMD_READ,  REG_DIV,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE, REG_DIV,  8'hAA, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_READ,  REG_DIV,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE, REG_TAC,  8'h01, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE, REG_TAC,  8'h05, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_TICK,  REG_DIV,  8'h00, 8'h10, 1'b0, 8'h00, 1'b0},
			'{CMD_WRITE, REG_TAC,  8'h06, 8'h00, 1'b1, 8'h00, 1'b0},
			'{CMD_TICK,  REG_DIV,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
			'{CMD_READ,  REG_TIMA, 8'h55, 8'hAA, 1'b0, 8'h00, 1'b0}
		};
		wait (arst_n);
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer(directed_rows[i]);
			pace_sender();
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 150)
				hold_off_req = 1'b1;
			offer(random_op());
			if (n == 350 || n == RANDOM_ITEMS - 1)
				drain_results();
			else
				pace_sender();
		end
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0 && timer_result_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : drive_ready
		ready_mode_t mode;
		int stretch;
		mode = READY_ALWAYS;
		stretch = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					mode = ready_mode_t'($urandom_range(0, 3));
					stretch = $urandom_range(8, 60);
				end
				stretch--;
				case (mode)
					READY_ALWAYS: m_tready <= 1'b1;
					READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
					READY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
					default:      m_tready <= ~m_tready;
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		timer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (timer_result_q.size() == 0) begin
				note_error("result with nothing expected", 0, m_tdata);
			end else begin
				want = timer_result_q.pop_front();
				if (m_tdata[7:0] !== want.read_data)
					note_error("read_data", want.read_data, m_tdata[7:0]);
				if (m_tdata[8] !== want.irq)
					note_error("overflow_irq", want.irq, m_tdata[8]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule

### divider_and_timer_counter_top.f
sv/dtc_pkg.sv
sv/dtc_divider.sv
sv/dtc_timer.sv
sv/divider_and_timer_counter_top.sv
tb/sv/testbench.sv
